// ===== design/alr_pkg.sv =====
package alr_pkg;

  // Design limits
  localparam int MAX_DEGREE  = 63;
  localparam int X_FRAC_BITS = 30;
  localparam int X_SHIFT     = X_FRAC_BITS - 30;

  // Field widths
  localparam int X_W       = 32;
  localparam int DEG_W     = 6;
  localparam int VAL_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 6;

  localparam int COEF_DEPTH = MAX_DEGREE + 1;
  localparam int SQRT_CELLS = 32;
  localparam int DEN_W      = 14;
  localparam int CNT_W      = 7;

  // 1/pi in Q30
  localparam logic [28:0] INV_PI_Q30 = 29'd341782637;

  // Divider step counts: 64 integer bits plus the fraction bits
  localparam logic [CNT_W-1:0] DIV_STEPS_INT = 7'd64;
  localparam logic [CNT_W-1:0] DIV_STEPS_C0  = 7'd124;
  localparam logic [CNT_W-1:0] DIV_STEPS_C1  = 7'd112;

  // Register indices
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_M    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_MODE  = 2'd2;

  localparam logic NORM_UNIT = 1'b0;

  typedef struct packed {
    logic             start;
    logic [63:0]      num;
    logic [DEN_W-1:0] den;
    logic [CNT_W-1:0] steps;
  } div_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_B_DIV,
    ST_B_DIVW,
    ST_B_MUL1,
    ST_B_MUL2,
    ST_B_SQ,
    ST_B_SQW,
    ST_C_SETUP,
    ST_C0_DIVW,
    ST_C0_SQW,
    ST_C1_DIVW,
    ST_C1_SQW,
    ST_C_WR,
    ST_X,
    ST_X_SQ,
    ST_X_SQW,
    ST_POW,
    ST_FIRST,
    ST_EMIT,
    ST_R_RD,
    ST_R_M1,
    ST_R_M2,
    ST_R_M3,
    ST_R_M4
  } alr_state_t;

endpackage

// ===== design/alr_if.sv =====
interface alr_in_if import alr_pkg::*;;
  logic           valid;
  logic           ready;
  logic [X_W-1:0] x_sample;

  modport source (output valid, output x_sample, input ready);
  modport sink   (input valid, input x_sample, output ready);
endinterface

interface alr_out_if import alr_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [DEG_W-1:0]        degree;
  logic signed [VAL_W-1:0] value;
  logic                    saturated;
  logic                    last;

  modport source (output valid, output degree, output value, output saturated, output last,
                  input ready);
  modport sink   (input valid, input degree, input value, input saturated, input last,
                  output ready);
endinterface

interface alr_cfg_if import alr_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/assoc_legendre_recurrence.sv =====
// After a sample request is taken, the results follow in order of degree
// while the sink keeps ready high.
// One sample at a time: a new sample is taken only after its last result is accepted.
// The first sample after reset or a register write first rebuilds the coefficient
// table.
// Reset (rst, synchronous) loads order_m 0, degree_max 63, norm_mode 0, table invalid.
module assoc_legendre_recurrence import alr_pkg::*; (
  input  logic clk,
  input  logic rst,
  alr_in_if.sink    sample,
  alr_out_if.source result,
  alr_cfg_if.sink   cfg
);

  // Control
  alr_state_t state, state_next;

  logic [DEG_W-1:0] order_m;
  logic [DEG_W-1:0] degree_max;
  logic             norm_mode;
  logic             table_valid;
  logic             out_vld;

  // Payload registers
  logic [X_W-1:0]          x_raw;
  logic [63:0]             t;
  logic [DEG_W-1:0]        idx;
  logic signed [31:0]      start_scale;
  logic [31:0]             c0;
  logic [31:0]             c1;
  logic signed [31:0]      xs;
  logic [61:0]             xsq;
  logic [30:0]             s;
  logic [31:0]             mag;
  logic signed [31:0]      p1;
  logic signed [31:0]      p2;
  logic [63:0]             rd_data;
  logic signed [63:0]      prod1;
  logic signed [64:0]      prod2;
  logic signed [35:0]      rsum;
  logic signed [68:0]      prod3;
  logic [DEG_W-1:0]        out_deg;
  logic signed [VAL_W-1:0] out_val;
  logic                    out_sat;
  logic                    out_last;

  logic [63:0] coef_mem [0:COEF_DEPTH-1];

  // Shared units
  div_req_t    div_req;
  logic        div_done;
  logic [63:0] div_quo;
  logic        sq_vld;
  logic [63:0] sq_arg;
  logic        rt_vld;
  logic [31:0] rt_val;

  // Derived values
  logic [DEG_W-1:0] tmax;
  logic [DEG_W-1:0] top_deg;
  logic             order_skip;
  logic             unit;
  logic             first_coef;
  logic [7:0]       odd;
  logic [7:0]       odd3;
  logic [13:0]      l_sq;
  logic [13:0]      m_sq;
  logic [13:0]      lm1_sq;
  logic [DEN_W-1:0] n0;
  logic [DEN_W-1:0] d0;
  logic [DEN_W-1:0] n1;
  logic [DEN_W-1:0] d1;
  logic [7:0]       c1_first;
  logic             x_neg;
  logic [32:0]      x_mag33;
  logic [63:0]      x_magw;
  logic [30:0]      x_mag;
  logic [31:0]      ss_mag;
  logic [63:0]      pow_prod;
  logic [32:0]      first_rnd;
  logic signed [65:0] sum;
  logic signed [44:0] v45;
  logic signed [31:0] v_sat;
  logic               v_clip;

  // half-away-from-zero rounding of the Q54 sum down to Q24
  function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
    logic [65:0] mg;
    logic [65:0] r;
    mg = v[65] ? 66'(-v) : 66'(v);
    r  = (mg + (66'd1 << 29)) >> 30;
    return v[65] ? -$signed(36'(r)) : $signed(36'(r));
  endfunction

  function automatic logic signed [44:0] rnd24(input logic signed [68:0] v);
    logic [68:0] mg;
    logic [68:0] r;
    mg = v[68] ? 69'(-v) : 69'(v);
    r  = (mg + (69'd1 << 23)) >> 24;
    return v[68] ? -$signed(45'(r)) : $signed(45'(r));
  endfunction

  always_comb begin
    tmax       = (degree_max > order_m) ? degree_max : order_m;
    top_deg    = (int'(tmax) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : tmax;
    order_skip = (int'(order_m) > MAX_DEGREE);
    unit       = (norm_mode == NORM_UNIT);
    first_coef = ({1'b0, idx} == ({1'b0, order_m} + 7'd1));

    // per-degree ratios of the coefficient table
    odd    = {1'b0, idx, 1'b0} - 8'd1;
    odd3   = {1'b0, idx, 1'b0} - 8'd3;
    l_sq   = 14'(idx) * 14'(idx);
    m_sq   = 14'(order_m) * 14'(order_m);
    lm1_sq = 14'(idx - 6'd1) * 14'(idx - 6'd1);
    n0     = lm1_sq - m_sq;
    d0     = unit ? (14'(odd) * 14'(odd3)) : (14'(odd) * 14'(odd));
    n1     = unit ? 14'((l_sq << 2) - 14'd1) : (14'(odd) * 14'(odd));
    d1     = l_sq - m_sq;
    c1_first = unit ? ({1'b0, order_m, 1'b0} + 8'd3) : ({1'b0, order_m, 1'b0} + 8'd1);

    // sample magnitude, rescaled to Q30 and clamped at one
    x_neg   = x_raw[X_W-1];
    x_mag33 = x_neg ? (33'h1_0000_0000 - {1'b0, x_raw}) : {1'b0, x_raw};
    x_magw  = (X_SHIFT >= 0) ? (64'(x_mag33) >> X_SHIFT) : (64'(x_mag33) << (-X_SHIFT));
    x_mag   = (x_magw > (64'd1 << 30)) ? 31'h4000_0000 : x_magw[30:0];

    ss_mag    = start_scale[31] ? (32'd0 - start_scale) : start_scale;
    pow_prod  = (64'(mag) * 64'(s)) + (64'd1 << 29);
    first_rnd = ({1'b0, mag} + 33'd32) >> 6;

    sum    = prod1 - prod2;
    v45    = rnd24(prod3);
    v_clip = (v45 > 45'sd2147483647) || (v45 < -45'sd2147483648);
    if (v45 > 45'sd2147483647) begin
      v_sat = 32'sh7FFF_FFFF;
    end else if (v45 < -45'sd2147483648) begin
      v_sat = -32'sh8000_0000;
    end else begin
      v_sat = v45[31:0];
    end
  end

  // Next state and unit requests
  always_comb begin
    state_next    = state;
    sq_vld        = 1'b0;
    sq_arg        = '0;
    div_req       = '0;
    case (state)
      ST_IDLE: begin
        if (sample.valid) begin
          if (table_valid) begin
            state_next = ST_X;
          end else if (order_m == '0) begin
            state_next = ST_B_MUL1;
          end else begin
            state_next = ST_B_DIV;
          end
        end
      end
      ST_B_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = t;
        div_req.den   = DEN_W'({idx, 1'b0});
        div_req.steps = DIV_STEPS_INT;
        state_next    = ST_B_DIVW;
      end
      ST_B_DIVW: begin
        if (div_done) begin
          state_next = (idx == order_m) ? ST_B_MUL1 : ST_B_DIV;
        end
      end
      ST_B_MUL1: state_next = unit ? ST_B_MUL2 : ST_B_SQ;
      ST_B_MUL2: state_next = ST_B_SQ;
      ST_B_SQ: begin
        sq_vld     = 1'b1;
        sq_arg     = t;
        state_next = ST_B_SQW;
      end
      ST_B_SQW: begin
        if (rt_vld) begin
          state_next = (order_m < top_deg) ? ST_C_SETUP : ST_X;
        end
      end
      ST_C_SETUP: begin
        if (first_coef) begin
          sq_vld     = 1'b1;
          sq_arg     = {c1_first, 56'd0} >> 8;
          state_next = ST_C1_SQW;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = 64'(n0);
          div_req.den   = d0;
          div_req.steps = DIV_STEPS_C0;
          state_next    = ST_C0_DIVW;
        end
      end
      ST_C0_DIVW: begin
        if (div_done) begin
          sq_vld     = 1'b1;
          sq_arg     = div_quo;
          state_next = ST_C0_SQW;
        end
      end
      ST_C0_SQW: begin
        if (rt_vld) begin
          div_req.start = 1'b1;
          div_req.num   = 64'(n1);
          div_req.den   = d1;
          div_req.steps = DIV_STEPS_C1;
          state_next    = ST_C1_DIVW;
        end
      end
      ST_C1_DIVW: begin
        if (div_done) begin
          sq_vld     = 1'b1;
          sq_arg     = div_quo;
          state_next = ST_C1_SQW;
        end
      end
      ST_C1_SQW: begin
        if (rt_vld) begin
          state_next = ST_C_WR;
        end
      end
      ST_C_WR: state_next = (idx == top_deg) ? ST_X : ST_C_SETUP;
      ST_X: state_next = ST_X_SQ;
      ST_X_SQ: begin
        sq_vld     = 1'b1;
        sq_arg     = (64'd1 << 60) - 64'(xsq);
        state_next = ST_X_SQW;
      end
      ST_X_SQW: begin
        if (rt_vld) begin
          state_next = (order_m == '0) ? ST_FIRST : ST_POW;
        end
      end
      ST_POW: begin
        if (idx == (order_m - 6'd1)) begin
          state_next = ST_FIRST;
        end
      end
      ST_FIRST: state_next = order_skip ? ST_IDLE : ST_EMIT;
      ST_EMIT: begin
        if (result.ready) begin
          state_next = out_last ? ST_IDLE : ST_R_RD;
        end
      end
      ST_R_RD: state_next = ST_R_M1;
      ST_R_M1: state_next = ST_R_M2;
      ST_R_M2: state_next = ST_R_M3;
      ST_R_M3: state_next = ST_R_M4;
      ST_R_M4: state_next = ST_EMIT;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Registers, table flag and the output request flag
  always_ff @(posedge clk) begin
    if (rst) begin
      order_m     <= '0;
      degree_max  <= 6'd63;
      norm_mode   <= 1'b0;
      table_valid <= 1'b0;
      out_vld     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_ORDER_M: begin
            order_m     <= cfg.data;
            table_valid <= 1'b0;
          end
          REG_DEGREE_MAX: begin
            degree_max  <= cfg.data;
            table_valid <= 1'b0;
          end
          REG_NORM_MODE: begin
            norm_mode   <= cfg.data[0];
            table_valid <= 1'b0;
          end
          default: ;
        endcase
      end
      if ((state == ST_B_SQW && rt_vld && !(order_m < top_deg)) ||
          (state == ST_C_WR && idx == top_deg)) begin
        table_valid <= 1'b1;
      end
      if ((state == ST_FIRST && !order_skip) || state == ST_R_M4) begin
        out_vld <= 1'b1;
      end else if (state == ST_EMIT && result.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        x_raw <= sample.x_sample;
        t     <= 64'd1 << 60;
        idx   <= 6'd1;
      end
      ST_B_DIVW: begin
        if (div_done) begin
          t <= t - div_quo;
          if (idx != order_m) begin
            idx <= idx + 6'd1;
          end
        end
      end
      // (2m+1) factor only for unit scaling
      ST_B_MUL1: begin
        if (unit) begin
          t <= 64'(t * 64'({order_m, 1'b1}));
        end
      end
      ST_B_MUL2: t <= 64'((64'(t >> 30) * 64'(INV_PI_Q30)) >> 2);
      ST_B_SQW: begin
        if (rt_vld) begin
          start_scale <= order_m[0] ? $signed(32'd0 - rt_val) : $signed(rt_val);
          idx         <= order_m + 6'd1;
        end
      end
      ST_C_SETUP: begin
        if (first_coef) begin
          c0 <= '0;
        end
      end
      ST_C0_SQW: begin
        if (rt_vld) begin
          c0 <= rt_val;
        end
      end
      ST_C1_SQW: begin
        if (rt_vld) begin
          c1 <= rt_val;
        end
      end
      ST_C_WR: idx <= idx + 6'd1;
      ST_X: begin
        xs  <= x_neg ? -$signed({1'b0, x_mag}) : $signed({1'b0, x_mag});
        xsq <= 62'(x_mag) * 62'(x_mag);
      end
      ST_X_SQW: begin
        if (rt_vld) begin
          s   <= rt_val[30:0];
          mag <= ss_mag;
          idx <= '0;
        end
      end
      ST_POW: begin
        mag <= pow_prod[61:30];
        idx <= idx + 6'd1;
      end
      ST_FIRST: begin
        p1       <= start_scale[31] ? -$signed(first_rnd[31:0]) : $signed(first_rnd[31:0]);
        p2       <= '0;
        out_deg  <= order_m;
        out_val  <= start_scale[31] ? -$signed(first_rnd[31:0]) : $signed(first_rnd[31:0]);
        out_sat  <= 1'b0;
        out_last <= (order_m == top_deg);
        idx      <= order_m;
      end
      ST_EMIT: begin
        if (result.ready) begin
          idx <= idx + 6'd1;
        end
      end
      ST_R_M1: begin
        prod1 <= xs * p1;
        prod2 <= $signed({1'b0, rd_data[31:0]}) * p2;
      end
      ST_R_M2: rsum <= rnd30(sum);
      ST_R_M3: prod3 <= $signed({1'b0, rd_data[63:32]}) * rsum;
      ST_R_M4: begin
        out_deg  <= idx;
        out_val  <= v_sat;
        out_sat  <= v_clip;
        out_last <= (idx == top_deg);
        p2       <= p1;
        p1       <= v_sat;
      end
      default: ;
    endcase
  end

  // Coefficient table: c1 in the upper word, c0 in the lower
  always_ff @(posedge clk) begin
    if (state == ST_C_WR) begin
      coef_mem[idx] <= {c1, c0};
    end
    if (state == ST_R_RD) begin
      rd_data <= coef_mem[idx];
    end
  end

  alr_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  alr_sqrt_chain u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .sq_vld (sq_vld),
    .sq_arg (sq_arg),
    .rt_vld (rt_vld),
    .rt_val (rt_val)
  );

  assign sample.ready     = (state == ST_IDLE);
  assign cfg.ready        = 1'b1;
  assign result.valid     = out_vld;
  assign result.degree    = out_deg;
  assign result.value     = out_val;
  assign result.saturated = out_sat;
  assign result.last      = out_last;

  // No new sample request while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    sample.ready |-> !result.valid)
    else $error("sample taken while a result is pending");

  // Divider completes only while a divide is awaited
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_B_DIVW || state == ST_C0_DIVW || state == ST_C1_DIVW))
    else $error("divider finished outside a wait state");

  // The closing result carries the top degree
  a_last_deg: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.last) |-> (result.degree == top_deg))
    else $error("last flag on wrong degree");

  // Table only drops out of date on a register write
  a_table_drop: assert property (@(posedge clk) disable iff (rst)
    ($fell(table_valid) && !$past(rst)) |-> $past(cfg.valid && cfg.ready))
    else $error("coefficient table invalidated without a write");

endmodule

// ===== design/alr_sqrt_cell.sv =====
module alr_sqrt_cell import alr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [4:0]  idx,
  input  logic        up_vld,
  input  logic [63:0] up_rem,
  input  logic [63:0] up_root,
  output logic        dn_vld,
  output logic [63:0] dn_rem,
  output logic [63:0] dn_root
);

  logic [63:0] bitv;
  logic [63:0] trial;
  logic        fits;

  // one digit pair of the restoring square root
  always_comb begin
    bitv  = 64'd1 << (6'd62 - {idx, 1'b0});
    trial = up_root + bitv;
    fits  = (up_rem >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_vld <= 1'b0;
    end else begin
      dn_vld <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (fits) begin
      dn_rem  <= up_rem - trial;
      dn_root <= (up_root >> 1) + bitv;
    end else begin
      dn_rem  <= up_rem;
      dn_root <= up_root >> 1;
    end
  end

endmodule

// ===== design/alr_sqrt_chain.sv =====
module alr_sqrt_chain import alr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        sq_vld,
  input  logic [63:0] sq_arg,
  output logic        rt_vld,
  output logic [31:0] rt_val
);

  logic        vld  [0:SQRT_CELLS];
  logic [63:0] rem  [0:SQRT_CELLS];
  logic [63:0] root [0:SQRT_CELLS];

  assign vld[0]  = sq_vld;
  assign rem[0]  = sq_arg;
  assign root[0] = 64'd0;

  for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_cell
    alr_sqrt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (5'(g)),
      .up_vld  (vld[g]),
      .up_rem  (rem[g]),
      .up_root (root[g]),
      .dn_vld  (vld[g+1]),
      .dn_rem  (rem[g+1]),
      .dn_root (root[g+1])
    );
  end

  assign rt_vld = vld[SQRT_CELLS];
  assign rt_val = root[SQRT_CELLS][31:0];

endmodule

// ===== design/alr_div.sv =====
module alr_div import alr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        done,
  output logic [63:0] quo
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [63:0]      num_sh;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   sh;
  logic             qbit;
  logic [DEN_W:0]   rem_next;

  // restoring division, one quotient bit per cycle
  always_comb begin
    sh       = {rem[DEN_W-1:0], num_sh[63]};
    qbit     = (sh >= {1'b0, den});
    rem_next = qbit ? (sh - {1'b0, den}) : sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_sh <= req.num;
      den    <= req.den;
      rem    <= '0;
      quo    <= '0;
    end else if (busy) begin
      num_sh <= num_sh << 1;
      rem    <= rem_next;
      quo    <= {quo[62:0], qbit};
    end
  end

endmodule
